### sv/smf_pkg.sv
package smf_pkg;

	localparam int MAX_CHARS = 64;
	localparam int DEVICES = 4;
	localparam int GAP_COLS = 10;
	localparam int GLYPH_W = 8;
	localparam int GLYPH_ROWS = 8;
	localparam int NUM_GLYPHS = 18;
	localparam int MARGIN = GLYPH_W * DEVICES;
	localparam int MARGIN_CHARS = (MARGIN + GAP_COLS - 1) / GAP_COLS;
	localparam int BIAS = MARGIN_CHARS * GAP_COLS - MARGIN;
	localparam int POS_W = 10;
	localparam int ADDR_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
	localparam int LEN_W = $clog2(MAX_CHARS + 1);
	localparam int DEV_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
	localparam int ROW_W = $clog2(GLYPH_ROWS);
	localparam int OFF_W = $clog2(GAP_COLS);
	localparam int QMAX = (MARGIN + GAP_COLS * MAX_CHARS + MARGIN + BIAS) / GAP_COLS + 1;
	localparam int Q_W = $clog2(QMAX + 1);
	localparam int EXT_W = 2 * GAP_COLS;
	localparam int PAD_W = GAP_COLS - GLYPH_W;

	localparam logic [1:0] FN_APPEND = 2'd0;
	localparam logic [1:0] FN_FRAME = 2'd1;
	localparam logic [1:0] FN_CLEAR = 2'd2;

	localparam logic [7:0] GLYPHS [NUM_GLYPHS][GLYPH_ROWS] = '{
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h3C, 8'h66, 8'hC3, 8'hC3, 8'hFF, 8'hC3, 8'hC3, 8'hC3},
		'{8'hFC, 8'hC6, 8'hC6, 8'hFC, 8'hC6, 8'hC6, 8'hC6, 8'hFC},
		'{8'h3E, 8'h60, 8'hC0, 8'hC0, 8'hC0, 8'hC0, 8'h60, 8'h3E},
		'{8'hF8, 8'hCC, 8'hC6, 8'hC6, 8'hC6, 8'hC6, 8'hCC, 8'hF8},
		'{8'hFF, 8'hC0, 8'hC0, 8'hFC, 8'hC0, 8'hC0, 8'hC0, 8'hFF},
		'{8'hFF, 8'hC0, 8'hC0, 8'hFC, 8'hC0, 8'hC0, 8'hC0, 8'hC0},
		'{8'h3E, 8'h60, 8'hC0, 8'hCE, 8'hC3, 8'h63, 8'h3E, 8'h00},
		'{8'hC3, 8'hC3, 8'hC3, 8'hFF, 8'hC3, 8'hC3, 8'hC3, 8'hC3},
		'{8'h3C, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h3C, 8'h00},
		'{8'h0E, 8'h06, 8'h06, 8'h06, 8'hC6, 8'hC6, 8'h7C, 8'h00},
		'{8'hC6, 8'hCC, 8'hD8, 8'hF0, 8'hF0, 8'hD8, 8'hCC, 8'hC6},
		'{8'hC0, 8'hC0, 8'hC0, 8'hC0, 8'hC0, 8'hC0, 8'hFF, 8'hFF},
		'{8'h81, 8'hC3, 8'hA5, 8'h99, 8'h81, 8'h81, 8'h81, 8'h81},
		'{8'h81, 8'hC1, 8'hA1, 8'h91, 8'h89, 8'h85, 8'h83, 8'h81},
		'{8'h3C, 8'h66, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'h66, 8'h3C},
		'{8'hFC, 8'hC6, 8'hC6, 8'hFC, 8'hD8, 8'hCC, 8'hC6, 8'hC3},
		'{8'h81, 8'h81, 8'h81, 8'h81, 8'h99, 8'hA5, 8'hC3, 8'h81}
	};

	typedef struct packed {
		logic wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0] wr_data;
		logic rd_en;
		logic [ADDR_W-1:0] rd_addr_a;
		logic [ADDR_W-1:0] rd_addr_b;
	} mem_req_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [DEV_W-1:0] dev;
		logic [OFF_W-1:0] col_off;
		logic a_ok;
		logic b_ok;
		logic done;
	} word_t;

	function automatic logic [GLYPH_W-1:0] glyph_row(input logic [7:0] ch,
		input logic [ROW_W-1:0] row);
		logic [4:0] gi;
		gi = 5'd0;
		if (ch >= 8'h61 && ch <= 8'h6F) begin
			gi = 5'(ch - 8'h60);
		end else if (ch == 8'h72) begin
			gi = 5'd16;
		end else if (ch == 8'h77) begin
			gi = 5'd17;
		end
		return GLYPHS[gi][row];
	endfunction

endpackage

### sv/smf_text_mem.sv
module smf_text_mem (
	input logic clk,
	input smf_pkg::mem_req_t req,
	output logic [7:0] rd_data_a,
	output logic [7:0] rd_data_b
);
	import smf_pkg::*;

	logic [7:0] mem [MAX_CHARS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_a <= mem[req.rd_addr_a];
			rd_data_b <= mem[req.rd_addr_b];
		end
	end

endmodule

### sv/smf_sequencer.sv
module smf_sequencer (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [1:0] func,
	input logic [7:0] char_code,
	output logic in_stall,
	input logic adv,
	output smf_pkg::mem_req_t req,
	output smf_pkg::word_t word_s1,
	output logic valid_s1
);
	import smf_pkg::*;

	logic [LEN_W-1:0] len_q;
	logic [POS_W-1:0] pos_q;
	logic [Q_W-1:0] pq_q;
	logic [OFF_W-1:0] pr_q;
	logic running_q;
	logic done_q;
	logic [ROW_W-1:0] row_q;
	logic [DEV_W-1:0] dev_q;
	logic [Q_W-1:0] fq_q;
	logic [OFF_W-1:0] fr_q;
	logic [Q_W-1:0] wq_q;
	logic [OFF_W-1:0] wr_q;

	logic acc;
	logic [POS_W:0] frames;
	logic [POS_W:0] pos_next;
	logic done_now;
	logic [Q_W-1:0] idx_a;
	logic [Q_W-1:0] idx_b;
	logic a_ok;
	logic b_ok;
	logic [OFF_W:0] step_sum;
	logic last_dev;

	assign in_stall = running_q;
	assign acc = in_valid && !running_q;
	assign frames = (POS_W + 1)'(MARGIN - 2) + ((POS_W + 1)'(len_q) << 3)
		+ ((POS_W + 1)'(len_q) << 1);
	assign pos_next = {1'b0, pos_q} + 1'b1;
	assign done_now = pos_next >= frames;

	assign idx_a = wq_q - Q_W'(MARGIN_CHARS);
	assign idx_b = idx_a + 1'b1;
	assign a_ok = (wq_q >= Q_W'(MARGIN_CHARS)) && (idx_a < Q_W'(len_q));
	assign b_ok = (wq_q + 1'b1 >= Q_W'(MARGIN_CHARS)) && (idx_b < Q_W'(len_q));
	assign step_sum = {1'b0, wr_q} + (OFF_W + 1)'(GLYPH_W);
	assign last_dev = dev_q == DEV_W'(DEVICES - 1);

	always_comb begin
		req.wr_en = acc && func == FN_APPEND && len_q < LEN_W'(MAX_CHARS);
		req.wr_addr = len_q[ADDR_W-1:0];
		req.wr_data = char_code;
		req.rd_en = running_q && adv;
		req.rd_addr_a = idx_a[ADDR_W-1:0];
		req.rd_addr_b = idx_b[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			pos_q <= '0;
			pq_q <= '0;
			pr_q <= OFF_W'(BIAS);
			running_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (req.wr_en) begin
				len_q <= len_q + 1'b1;
			end
			if (acc && func == FN_CLEAR) begin
				len_q <= '0;
				pos_q <= '0;
				pq_q <= '0;
				pr_q <= OFF_W'(BIAS);
			end
			if (acc && func == FN_FRAME) begin
				running_q <= 1'b1;
				if (done_now) begin
					pos_q <= '0;
					pq_q <= '0;
					pr_q <= OFF_W'(BIAS);
				end else begin
					pos_q <= pos_next[POS_W-1:0];
					if (pr_q == OFF_W'(GAP_COLS - 1)) begin
						pr_q <= '0;
						pq_q <= pq_q + 1'b1;
					end else begin
						pr_q <= pr_q + 1'b1;
					end
				end
			end
			if (adv) begin
				valid_s1 <= running_q;
				if (running_q && last_dev && row_q == ROW_W'(GLYPH_ROWS - 1)) begin
					running_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && func == FN_FRAME) begin
			done_q <= done_now;
			row_q <= '0;
			dev_q <= '0;
			fq_q <= pq_q;
			fr_q <= pr_q;
			wq_q <= pq_q;
			wr_q <= pr_q;
		end else if (running_q && adv) begin
			if (last_dev) begin
				dev_q <= '0;
				row_q <= row_q + 1'b1;
				wq_q <= fq_q;
				wr_q <= fr_q;
			end else begin
				dev_q <= dev_q + 1'b1;
				if (step_sum >= (OFF_W + 1)'(GAP_COLS)) begin
					wr_q <= OFF_W'(step_sum - (OFF_W + 1)'(GAP_COLS));
					wq_q <= wq_q + 1'b1;
				end else begin
					wr_q <= step_sum[OFF_W-1:0];
				end
			end
		end
		if (adv) begin
			word_s1.row <= row_q;
			word_s1.dev <= dev_q;
			word_s1.col_off <= wr_q;
			word_s1.a_ok <= a_ok;
			word_s1.b_ok <= b_ok;
			word_s1.done <= done_q;
		end
	end

endmodule

### sv/smf_render.sv
module smf_render (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic valid_s1,
	input smf_pkg::word_t word_s1,
	input logic [7:0] rd_data_a,
	input logic [7:0] rd_data_b,
	output logic out_valid,
	output logic [3:0] row_address,
	output logic [7:0] row_pixels,
	output logic [1:0] device_slot,
	output logic latch_after,
	output logic frame_last,
	output logic scroll_done
);
	import smf_pkg::*;

	logic [GLYPH_W-1:0] ga;
	logic [GLYPH_W-1:0] gb;
	logic [EXT_W-1:0] ext;
	logic [EXT_W-1:0] shifted;
	logic last_dev;

	assign ga = word_s1.a_ok ? glyph_row(rd_data_a, word_s1.row) : '0;
	assign gb = word_s1.b_ok ? glyph_row(rd_data_b, word_s1.row) : '0;
	assign ext = {ga, PAD_W'(0), gb, PAD_W'(0)};
	assign shifted = ext << word_s1.col_off;
	assign last_dev = word_s1.dev == DEV_W'(DEVICES - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_address <= 4'(word_s1.row) + 4'd1;
			row_pixels <= shifted[EXT_W-1 -: GLYPH_W];
			device_slot <= 2'(word_s1.dev);
			latch_after <= last_dev;
			frame_last <= last_dev && word_s1.row == ROW_W'(GLYPH_ROWS - 1);
			scroll_done <= word_s1.done;
		end
	end

endmodule

### sv/scrolling_text_marquee_framer_top.sv
// Append and clear transfers leave the block ready again at once. A frame request puts
// out 32 row words, one per cycle while the output is not stalled, each registered in
// stage one and then at the output; the word walk reads two text characters per word
// from the dual-read store. Input stalls during the walk, which ends while words drain.
// Reset clears text length, scroll position and all valid flags; the text store is
// not cleared, since only characters below the text length are ever shown.
module scrolling_text_marquee_framer_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] func,
	input logic [7:0] char_code,
	output logic out_valid,
	input logic out_stall,
	output logic [3:0] row_address,
	output logic [7:0] row_pixels,
	output logic [1:0] device_slot,
	output logic latch_after,
	output logic frame_last,
	output logic scroll_done
);
	import smf_pkg::*;

	mem_req_t req;
	word_t word_s1;
	logic valid_s1;
	logic adv;
	logic [7:0] rd_data_a;
	logic [7:0] rd_data_b;

	assign adv = !(out_valid && out_stall);

	smf_sequencer u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.func(func),
		.char_code(char_code),
		.in_stall(in_stall),
		.adv(adv),
		.req(req),
		.word_s1(word_s1),
		.valid_s1(valid_s1)
	);

	smf_text_mem u_mem (
		.clk(clk),
		.req(req),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

	smf_render u_render (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.valid_s1(valid_s1),
		.word_s1(word_s1),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b),
		.out_valid(out_valid),
		.row_address(row_address),
		.row_pixels(row_pixels),
		.device_slot(device_slot),
		.latch_after(latch_after),
		.frame_last(frame_last),
		.scroll_done(scroll_done)
	);

endmodule

### sv/smf_checker.sv
module smf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [1:0] func,
	input logic out_valid,
	input logic out_stall,
	input logic [3:0] row_address,
	input logic [7:0] row_pixels,
	input logic [1:0] device_slot,
	input logic latch_after,
	input logic frame_last
);
	import smf_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(row_pixels) && $stable(row_address))
		else $error("Stalled output transfer changed.");

	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> latch_after && row_address == 4'(GLYPH_ROWS))
		else $error("Final word of a frame is not the last word of the last row.");

	a_latch_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && latch_after |-> device_slot == 2'(DEVICES - 1))
		else $error("Latch flagged on a word that is not for the last device.");

	a_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == FN_FRAME |=> in_stall)
		else $error("Input not stalled after a frame request transfer.");

endmodule

bind scrolling_text_marquee_framer_top smf_checker u_chk (.*);
